/* hw/rtl/fpa_pkg.sv */
// Package with shared types, action codes and constants of the fixed-point ALU.
`default_nettype none
package fpa_pkg;
  localparam int FRAC_BITS = 8;
  localparam int DATA_W = 32;
  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam int DIV_STEPS = NUM_W;
  localparam int STAGES = DIV_STEPS + 3;

  localparam logic [3:0] ACT_ADD = 4'd0;
  localparam logic [3:0] ACT_SUB = 4'd1;
  localparam logic [3:0] ACT_MUL = 4'd2;
  localparam logic [3:0] ACT_DIV = 4'd3;
  localparam logic [3:0] ACT_GT = 4'd4;
  localparam logic [3:0] ACT_LT = 4'd5;
  localparam logic [3:0] ACT_GE = 4'd6;
  localparam logic [3:0] ACT_LE = 4'd7;
  localparam logic [3:0] ACT_EQ = 4'd8;
  localparam logic [3:0] ACT_NE = 4'd9;
  localparam logic [3:0] ACT_MIN = 4'd10;
  localparam logic [3:0] ACT_MAX = 4'd11;
  localparam logic [3:0] ACT_INC = 4'd12;
  localparam logic [3:0] ACT_DEC = 4'd13;
  localparam logic [3:0] ACT_FROM_INT = 4'd14;
  localparam logic [3:0] ACT_TO_INT = 4'd15;

  typedef struct packed {
    logic [3:0] action;
    logic [DATA_W-1:0] simple;
    logic compare_true;
    logic is_div;
    logic is_mul;
    logic div_zero;
    logic neg;
  } ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic compare_true;
    logic divide_error;
  } res_t;
endpackage
`default_nettype wire

/* hw/rtl/fixed_point_alu.sv */
// Top level of the pipelined fixed-point ALU.
`default_nettype none
// Signed Q fixed-point ALU with FRAC_BITS fraction bits. One transfer is taken
// every cycle while the output is not stalled; each yields one result. The
// divider resolves one quotient bit per stage over 40 stages. All actions go
// through the same pipeline, so order is kept. The whole pipeline holds when
// s_tready is low.
module fixed_point_alu (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tvalid,
  output logic s_tready,
  // Fields from bit 0 up: operand_a[31:0], operand_b[63:32].
  input wire logic [63:0] s_tdata,
  // Fields: action[3:0].
  input wire logic [3:0] s_tuser,
  output logic m_tvalid,
  input wire logic m_tready,
  // Fields from bit 0 up: result_value[31:0], compare_true[32], divide_error[33],
  // zero fill.
  output logic [39:0] m_tdata
);
  localparam int W = fpa_pkg::DATA_W;
  logic en;
  logic [fpa_pkg::STAGES-1:0] vld;
  fpa_pkg::ctl_t ctl_a;
  fpa_pkg::ctl_t ctl_b;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic [fpa_pkg::NUM_W-1:0] quot;
  logic [2*W-1:0] prod;
  fpa_pkg::res_t res;

  assign en = !vld[fpa_pkg::STAGES-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[fpa_pkg::STAGES-1];
  assign m_tdata = {6'd0, res.divide_error, res.compare_true, res.result_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[fpa_pkg::STAGES-2:0], s_tvalid};
    end
  end

  fpa_front u_front (
    .clk(clk), .en(en), .action(s_tuser),
    .operand_a(s_tdata[W-1:0]), .operand_b(s_tdata[2*W-1:W]),
    .ctl(ctl_a), .mag_a(mag_a), .mag_b(mag_b)
  );

  fpa_divmul u_divmul (
    .clk(clk), .en(en), .ctl_in(ctl_a), .mag_a(mag_a), .mag_b(mag_b),
    .ctl_out(ctl_b), .quot(quot), .prod(prod)
  );

  fpa_final u_final (.clk(clk), .en(en), .ctl(ctl_b), .quot(quot), .prod(prod), .res(res));

  a_err_div: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[33] |-> m_tdata[31:0] == '0)
    else $error("divide error with nonzero result");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[32] && m_tdata[33]))
    else $error("compare and divide error both set");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result lost under stall");
endmodule
`default_nettype wire

/* hw/rtl/fpa_front.sv */
// Input decode stage: simple actions, comparisons and operand magnitudes.
`default_nettype none
module fpa_front (
  input wire logic clk,
  input wire logic en,
  input wire logic [3:0] action,
  input wire logic signed [fpa_pkg::DATA_W-1:0] operand_a,
  input wire logic signed [fpa_pkg::DATA_W-1:0] operand_b,
  output fpa_pkg::ctl_t ctl,
  output logic [fpa_pkg::DATA_W-1:0] mag_a,
  output logic [fpa_pkg::DATA_W-1:0] mag_b
);
  fpa_pkg::ctl_t ctl_next;
  logic lt;
  logic eq;

  always_comb begin
    lt = operand_a < operand_b;
    eq = operand_a == operand_b;
    ctl_next = '0;
    ctl_next.action = action;
    ctl_next.is_div = action == fpa_pkg::ACT_DIV;
    ctl_next.is_mul = action == fpa_pkg::ACT_MUL;
    ctl_next.div_zero = operand_b == '0;
    ctl_next.neg = operand_a[fpa_pkg::DATA_W-1] ^ operand_b[fpa_pkg::DATA_W-1];
    case (action)
      fpa_pkg::ACT_ADD: ctl_next.simple = operand_a + operand_b;
      fpa_pkg::ACT_SUB: ctl_next.simple = operand_a - operand_b;
      fpa_pkg::ACT_GT: ctl_next.compare_true = !lt && !eq;
      fpa_pkg::ACT_LT: ctl_next.compare_true = lt;
      fpa_pkg::ACT_GE: ctl_next.compare_true = !lt;
      fpa_pkg::ACT_LE: ctl_next.compare_true = lt || eq;
      fpa_pkg::ACT_EQ: ctl_next.compare_true = eq;
      fpa_pkg::ACT_NE: ctl_next.compare_true = !eq;
      fpa_pkg::ACT_MIN: ctl_next.simple = lt ? operand_a : operand_b;
      fpa_pkg::ACT_MAX: ctl_next.simple = (!lt && !eq) ? operand_a : operand_b;
      fpa_pkg::ACT_INC: ctl_next.simple = operand_a + {{(fpa_pkg::DATA_W-1){1'b0}}, 1'b1};
      fpa_pkg::ACT_DEC: ctl_next.simple = operand_a - {{(fpa_pkg::DATA_W-1){1'b0}}, 1'b1};
      fpa_pkg::ACT_FROM_INT: ctl_next.simple = operand_a <<< fpa_pkg::FRAC_BITS;
      fpa_pkg::ACT_TO_INT: ctl_next.simple = operand_a >>> fpa_pkg::FRAC_BITS;
      default: ctl_next.simple = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl <= ctl_next;
      mag_a <= operand_a[fpa_pkg::DATA_W-1] ? -operand_a : operand_a;
      mag_b <= operand_b[fpa_pkg::DATA_W-1] ? -operand_b : operand_b;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/fpa_divmul.sv */
// Pipelined unsigned restoring divider with a multiplier on its first stage.
`default_nettype none
module fpa_divmul (
  input wire logic clk,
  input wire logic en,
  input wire fpa_pkg::ctl_t ctl_in,
  input wire logic [fpa_pkg::DATA_W-1:0] mag_a,
  input wire logic [fpa_pkg::DATA_W-1:0] mag_b,
  output fpa_pkg::ctl_t ctl_out,
  output logic [fpa_pkg::NUM_W-1:0] quot,
  output logic [2*fpa_pkg::DATA_W-1:0] prod
);
  localparam int N = fpa_pkg::DIV_STEPS;
  localparam int W = fpa_pkg::DATA_W;
  localparam int NW = fpa_pkg::NUM_W;

  fpa_pkg::ctl_t ctl_s [N+1];
  logic [NW-1:0] num_s [N+1];
  logic [W:0] rem_s [N+1];
  logic [W-1:0] den_s [N+1];
  logic [2*W-1:0] prod_s [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_s[0] <= ctl_in;
      num_s[0] <= {mag_a, {fpa_pkg::FRAC_BITS{1'b0}}};
      rem_s[0] <= '0;
      den_s[0] <= mag_b;
      prod_s[0] <= mag_a * mag_b;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [W:0] trial;
    logic [W+1:0] diff;
    always_comb begin
      trial = {rem_s[i][W-1:0], num_s[i][NW-1]};
      diff = {1'b0, trial} - {2'b00, den_s[i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ctl_s[i+1] <= ctl_s[i];
        den_s[i+1] <= den_s[i];
        prod_s[i+1] <= prod_s[i];
        rem_s[i+1] <= diff[W+1] ? trial : diff[W:0];
        num_s[i+1] <= {num_s[i][NW-2:0], !diff[W+1]};
      end
    end
  end

  assign ctl_out = ctl_s[N];
  assign quot = num_s[N];
  assign prod = prod_s[N];
endmodule
`default_nettype wire

/* hw/rtl/fpa_final.sv */
// Final stage: sign fix-up of multiply and divide and result selection.
`default_nettype none
module fpa_final (
  input wire logic clk,
  input wire logic en,
  input wire fpa_pkg::ctl_t ctl,
  input wire logic [fpa_pkg::NUM_W-1:0] quot,
  input wire logic [2*fpa_pkg::DATA_W-1:0] prod,
  output fpa_pkg::res_t res
);
  localparam int W = fpa_pkg::DATA_W;
  fpa_pkg::res_t res_next;
  logic [W-1:0] mq;
  logic [W-1:0] dq;

  always_comb begin
    mq = prod[fpa_pkg::FRAC_BITS +: W];
    dq = quot[W-1:0];
    res_next = '0;
    res_next.compare_true = ctl.compare_true;
    if (ctl.is_mul) begin
      res_next.result_value = ctl.neg ? -mq : mq;
    end else if (ctl.is_div) begin
      res_next.divide_error = ctl.div_zero;
      res_next.result_value = ctl.div_zero ? '0 : (ctl.neg ? -dq : dq);
    end else begin
      res_next.result_value = ctl.simple;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end
endmodule
`default_nettype wire

/* dv/tb.sv */
// Testbench for the fixed-point ALU: random and directed stimulus checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import fpa_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic cmp;
    logic err;
  } alu_res_t;

  class alu_scoreboard;
    alu_res_t pending[$];
    int mismatches;

    function alu_res_t compute(logic [3:0] act, logic [31:0] a, logic [31:0] b);
      alu_res_t r;
      logic signed [63:0] sa;
      logic signed [63:0] sb;
      logic signed [63:0] wide;
      sa = {{32{a[31]}}, a};
      sb = {{32{b[31]}}, b};
      r = '0;
      case (act)
        ACT_ADD: r.value = a + b;
        ACT_SUB: r.value = a - b;
        ACT_MUL: begin
          wide = (sa * sb) / (64'sd1 <<< FRAC_BITS);
          r.value = wide[31:0];
        end
        ACT_DIV: begin
          if (b == 0) begin
            r.err = 1'b1;
          end else begin
            wide = (sa * (64'sd1 <<< FRAC_BITS)) / sb;
            r.value = wide[31:0];
          end
        end
        ACT_GT: r.cmp = sa > sb;
        ACT_LT: r.cmp = sa < sb;
        ACT_GE: r.cmp = sa >= sb;
        ACT_LE: r.cmp = sa <= sb;
        ACT_EQ: r.cmp = sa == sb;
        ACT_NE: r.cmp = sa != sb;
        ACT_MIN: r.value = (sa < sb) ? a : b;
        ACT_MAX: r.value = (sa > sb) ? a : b;
        ACT_INC: r.value = a + 32'd1;
        ACT_DEC: r.value = a - 32'd1;
        ACT_FROM_INT: r.value = a << FRAC_BITS;
        default: r.value = $signed(a) >>> FRAC_BITS;
      endcase
      return r;
    endfunction

    function void note_input(logic [3:0] act, logic [31:0] a, logic [31:0] b);
      pending.push_back(compute(act, a, b));
    endfunction

    function void check_result(logic [39:0] data);
      alu_res_t want;
      alu_res_t got;
      got = {data[31:0], data[32], data[33]};
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", data);
        return;
      end
      want = pending.pop_front();
      if (got !== want || data[39:34] !== 6'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value %h cmp %b err %b, got value %h cmp %b err %b",
                   want.value, want.cmp, want.err, got.value, got.cmp, got.err);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic [3:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [39:0] m_tdata;

  alu_scoreboard board = new();
  bit quiet = 0;
  bit hold_sink = 0;
  int idle_cycles = 0;

  fixed_point_alu dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
    if (!rst && ((m_tvalid && m_tready) || (s_tvalid && s_tready))) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 5000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random bursts of stall, or a long hold when asked.
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_sink) begin
        m_tready <= 0;
        repeat (300) @(negedge clk);
        hold_sink = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 0;
        n = $urandom_range(1, 10);
        repeat (n) @(negedge clk);
      end else begin
        m_tready <= 1;
        @(negedge clk);
      end
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(0, 2047) - 1024;
      4: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [3:0] act, logic [31:0] a, logic [31:0] b);
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      n = $urandom_range(1, 10);
      repeat (n) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= act;
    s_tdata <= {b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_input(act, a, b);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [3:0] act;
    logic [31:0] ext[5];
    ext = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'hffff_ffff, 32'd1};
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    for (int i = 0; i < 16; i++) begin
      act = 4'(i);
      send_item(act, ext[i % 5], ext[(i + 2) % 5]);
    end
    send_item(ACT_DIV, 32'h0000_0500, 32'd0);
    send_item(ACT_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_item(ACT_MUL, 32'h8000_0000, 32'h8000_0000);
    send_item(ACT_TO_INT, 32'hffff_ff01, 32'd0);
    send_item(ACT_EQ, 32'h1234, 32'h1234);
    send_item(ACT_MIN, 32'h55, 32'h55);
    drain();
    hold_sink = 1;
    for (int i = 0; i < 80; i++) begin
      act = 4'($urandom);
      send_item(act, pick_operand(), pick_operand());
    end
    drain();
    for (int i = 0; i < 470; i++) begin
      if (i == 400) quiet = 1;
      act = 4'($urandom);
      send_item(act, pick_operand(), pick_operand());
    end
    drain();
    repeat (60) @(negedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
